@@ rtl/core/sugf_pkg.sv @@
// Shared types, constants and the FIR coefficient table for the stereo upmix block.
// No dependencies; sugf_mac and the top module use it by scoped names.
package sugf_pkg;

    localparam int NUM_CH   = 5;
    localparam int ACC_W    = 72;
    localparam int GAIN_W   = 63;
    localparam int CLIP_W   = 31;
    localparam int CFG_IDX_W = 3;

    localparam logic [2:0] CH_LAST = 3'(NUM_CH - 1);

    // Configuration register indexes; gains occupy indexes 0 to NUM_CH-1.
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LAST     = 3'(NUM_CH - 1);
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEVEL    = 3'd6;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 63'd5819551150079073351;
    localparam logic [CLIP_W-1:0] CLIP_RESET = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] in_left;
        logic signed [31:0] in_right;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_front_left;
        logic signed [31:0] out_front_right;
        logic signed [31:0] out_surround_left;
        logic signed [31:0] out_surround_right;
        logic signed [31:0] out_center;
    } t_out_item;

    typedef enum logic [1:0] {
        MAC_FULL,
        MAC_SHR31,
        MAC_SHR31_X16
    } t_mac_mode;

    typedef struct packed {
        logic      valid;
        logic      clear;
        t_mac_mode mode;
    } t_mac_op;

    typedef struct packed {
        logic               valid;
        logic               clear;
        logic               ent_valid;
        logic signed [31:0] coef;
    } t_tap_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIX_A,
        S_MIX_B,
        S_MIX_WAIT,
        S_MIX_CLIP,
        S_TAPS,
        S_DRAIN1,
        S_DRAIN2,
        S_FIR_CLIP,
        S_DONE
    } t_state;

    // Coefficient by distance from the filter center, 1.31.
    function automatic logic signed [31:0] coef_by_dist(input logic [3:0] d);
        logic signed [31:0] c;
        unique case (d)
            4'd0:  c = 32'sd1849143033;
            4'd1:  c = 32'sd279245158;
            4'd2:  c = -32'sd230455505;
            4'd3:  c = 32'sd171585654;
            4'd4:  c = -32'sd116806448;
            4'd5:  c = 32'sd72594433;
            4'd6:  c = -32'sd40479528;
            4'd7:  c = 32'sd19267858;
            4'd8:  c = -32'sd6613713;
            4'd9:  c = -32'sd5701;
            4'd10: c = 32'sd2780218;
            4'd11: c = -32'sd3373816;
            4'd12: c = 32'sd2920441;
            4'd13: c = -32'sd2112425;
            4'd14: c = 32'sd1318368;
            4'd15: c = -32'sd694687;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/sugf_mac.sv @@
// Shared multiply-accumulate unit: a registered 32x32 product followed by a 72-bit accumulator.
// Depends on sugf_pkg for the operation struct and accumulator width.
module sugf_mac (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sugf_pkg::t_mac_op              i_op,
    input  logic signed [31:0]             i_a,
    input  logic signed [31:0]             i_b,
    output logic signed [sugf_pkg::ACC_W-1:0] o_acc
);

    logic signed [63:0]                r_prod;
    sugf_pkg::t_mac_op                 r_op;
    logic signed [sugf_pkg::ACC_W-1:0] r_acc;
    logic signed [sugf_pkg::ACC_W-1:0] term;
    logic signed [sugf_pkg::ACC_W-1:0] prod_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= '0;
        end else begin
            r_op <= i_op;
        end
        r_prod <= i_a * i_b;
    end

    assign prod_x = sugf_pkg::ACC_W'(r_prod);

    // The shifted modes floor the product to 1.31 before it is added.
    always_comb begin
        unique case (r_op.mode)
            sugf_pkg::MAC_FULL:      term = prod_x;
            sugf_pkg::MAC_SHR31:     term = prod_x >>> 31;
            sugf_pkg::MAC_SHR31_X16: term = (prod_x >>> 31) <<< 4;
            default:                 term = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_op.valid) begin
            r_acc <= (r_op.clear ? '0 : r_acc) + term;
        end
    end

    assign o_acc = r_acc;

endmodule

@@ rtl/core/sugf_dline.sv @@
// Delay-line storage for all five FIR channels: one write port and one registered read port.
// Depends on nothing but its parameters.
module sugf_dline #(
    parameter int DEPTH = 155,
    parameter int AW    = 8
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic signed [31:0]    i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output logic signed [31:0]    o_rdata
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/stereo_upmix_gain_fir_top.sv @@
// Stereo to five-channel upmix with per-channel symmetric FIR low-pass.
// One shared 32x32 MAC does every gain and tap product in turn, so a new item is taken only
// after the previous one has finished its pass through all channels, filtered or bypassed.
// The output register lets the next item be accepted while a result waits to be taken.
// Reset (synchronous, active low) restores register defaults and marks the delay lines empty:
// entries not yet written since reset read as zero through a fill flag, with no clearing pass.
module stereo_upmix_gain_fir_top #(
    parameter int TAPS        = 31,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sugf_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sugf_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_wr_en,
    input  logic [sugf_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [sugf_pkg::GAIN_W-1:0]         i_cfg_wr_data
);

    localparam int PW    = $clog2(TAPS);
    localparam int DEPTH = sugf_pkg::NUM_CH * TAPS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SH    = 32 - SAMPLE_BITS;
    localparam logic [31:0] OUT_MASK = 32'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [30:0] SMAX     = 31'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [PW-1:0] POS_LAST = PW'(TAPS - 1);
    localparam logic [7:0]    TM1      = 8'(TAPS - 1);

    // Configuration registers.
    logic [sugf_pkg::GAIN_W-1:0] r_gain [sugf_pkg::NUM_CH];
    logic                        r_filt_en;
    logic [sugf_pkg::CLIP_W-1:0] r_clip;

    // Sequencer and datapath registers.
    sugf_pkg::t_state    r_state, n_state;
    logic signed [31:0]  r_l, n_l;
    logic signed [31:0]  r_r, n_r;
    logic [2:0]          r_ch, n_ch;
    logic [AW-1:0]       r_base, n_base;
    logic [PW-1:0]       r_k, n_k;
    logic [PW-1:0]       r_ridx, n_ridx;
    logic [PW-1:0]       r_pos, n_pos;
    logic                r_full, n_full;
    sugf_pkg::t_tap_ctl  r_tap, n_tap;
    logic signed [31:0]  r_res [sugf_pkg::NUM_CH];
    logic signed [31:0]  n_res [sugf_pkg::NUM_CH];
    sugf_pkg::t_out_item r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic [sugf_pkg::GAIN_W-1:0]       gain_sel;
    logic signed [31:0]                gain_a, gain_b;
    logic [30:0]                       lim;
    logic signed [sugf_pkg::ACC_W-1:0] acc;
    logic signed [31:0]                y_mix, y_fir;
    logic signed [31:0]                rdata;
    logic signed [31:0]                mac_a, mac_b;
    sugf_pkg::t_mac_op                 mac_op;
    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr, mem_raddr;
    logic [7:0]                        two_k, dist2;
    logic [6:0]                        tap_dist;
    logic signed [31:0]                coef_k;
    logic                              out_free;

    function automatic logic signed [31:0] clip_to(
        input logic signed [sugf_pkg::ACC_W-1:0] v,
        input logic [30:0]                       l
    );
        logic signed [sugf_pkg::ACC_W-1:0] lx;
        logic signed [31:0]                r;
        lx = signed'(sugf_pkg::ACC_W'(l));
        if (v > lx) begin
            r = signed'({1'b0, l});
        end else if (v < -lx) begin
            r = -signed'({1'b0, l});
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sugf_pkg::NUM_CH; i++) begin
                r_gain[i] <= sugf_pkg::GAIN_RESET;
            end
            r_filt_en <= 1'b1;
            r_clip    <= sugf_pkg::CLIP_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_addr <= sugf_pkg::CFG_GAIN_LAST) begin
                r_gain[i_cfg_addr] <= i_cfg_wr_data;
            end else if (i_cfg_addr == sugf_pkg::CFG_FILTER_ENABLE) begin
                r_filt_en <= i_cfg_wr_data[0];
            end else if (i_cfg_addr == sugf_pkg::CFG_CLIP_LEVEL) begin
                r_clip <= i_cfg_wr_data[sugf_pkg::CLIP_W-1:0];
            end
        end
    end

    assign gain_sel = r_gain[r_ch];
    assign gain_a   = signed'({1'b0, gain_sel[62:32]});
    assign gain_b   = signed'(gain_sel[31:0]);
    assign lim      = (r_clip > SMAX) ? SMAX : r_clip;
    assign y_mix    = clip_to(acc, lim);
    assign y_fir    = clip_to(acc >>> 31, lim);
    assign out_free = !r_out_valid || i_out_ready;

    // Tap k and tap TAPS-1-k share the coefficient at distance |2k-(TAPS-1)|/2.
    assign two_k    = 8'({r_k, 1'b0});
    assign dist2    = (two_k >= TM1) ? (two_k - TM1) : (TM1 - two_k);
    assign tap_dist = dist2[7:1];
    assign coef_k   = (tap_dist < 7'd16) ? sugf_pkg::coef_by_dist(tap_dist[3:0]) : '0;

    // Shared MAC operand select: tap operands enter the MAC in the cycle after their read.
    always_comb begin
        mac_a  = r_l;
        mac_b  = gain_a;
        mac_op = '{valid: 1'b0, clear: 1'b0, mode: sugf_pkg::MAC_FULL};
        if (r_tap.valid) begin
            mac_a  = r_tap.ent_valid ? rdata : '0;
            mac_b  = r_tap.coef;
            mac_op = '{valid: 1'b1, clear: r_tap.clear, mode: sugf_pkg::MAC_FULL};
        end else if (r_state == sugf_pkg::S_MIX_A) begin
            mac_op = '{valid: 1'b1, clear: 1'b1, mode: sugf_pkg::MAC_SHR31};
        end else if (r_state == sugf_pkg::S_MIX_B) begin
            mac_a  = r_r;
            mac_b  = gain_b;
            mac_op = '{valid: 1'b1, clear: 1'b0, mode: sugf_pkg::MAC_SHR31_X16};
        end
    end

    sugf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mac_op),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (acc)
    );

    assign mem_we    = (r_state == sugf_pkg::S_MIX_CLIP) && r_filt_en;
    assign mem_waddr = r_base + AW'(r_pos);
    assign mem_raddr = r_base + AW'(r_ridx);

    sugf_dline #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_dline (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (y_mix),
        .i_raddr (mem_raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sugf_pkg::S_IDLE:     if (i_in_valid) n_state = sugf_pkg::S_MIX_A;
            sugf_pkg::S_MIX_A:    n_state = sugf_pkg::S_MIX_B;
            sugf_pkg::S_MIX_B:    n_state = sugf_pkg::S_MIX_WAIT;
            sugf_pkg::S_MIX_WAIT: n_state = sugf_pkg::S_MIX_CLIP;
            sugf_pkg::S_MIX_CLIP: begin
                if (r_filt_en) begin
                    n_state = sugf_pkg::S_TAPS;
                end else if (r_ch == sugf_pkg::CH_LAST) begin
                    n_state = sugf_pkg::S_DONE;
                end else begin
                    n_state = sugf_pkg::S_MIX_A;
                end
            end
            sugf_pkg::S_TAPS:     if (r_k == POS_LAST) n_state = sugf_pkg::S_DRAIN1;
            sugf_pkg::S_DRAIN1:   n_state = sugf_pkg::S_DRAIN2;
            sugf_pkg::S_DRAIN2:   n_state = sugf_pkg::S_FIR_CLIP;
            sugf_pkg::S_FIR_CLIP: begin
                n_state = (r_ch == sugf_pkg::CH_LAST) ? sugf_pkg::S_DONE : sugf_pkg::S_MIX_A;
            end
            sugf_pkg::S_DONE:     if (out_free) n_state = sugf_pkg::S_IDLE;
            default:              n_state = sugf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_l         = r_l;
        n_r         = r_r;
        n_ch        = r_ch;
        n_base      = r_base;
        n_k         = r_k;
        n_ridx      = r_ridx;
        n_pos       = r_pos;
        n_full      = r_full;
        n_tap       = '0;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            sugf_pkg::S_IDLE: begin
                n_l    = (i_in.in_left <<< SH) >>> SH;
                n_r    = (i_in.in_right <<< SH) >>> SH;
                n_ch   = '0;
                n_base = '0;
            end
            sugf_pkg::S_MIX_CLIP: begin
                if (r_filt_en) begin
                    n_k    = '0;
                    n_ridx = (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
                end else begin
                    n_res[r_ch] = y_mix;
                    n_ch        = r_ch + 1'b1;
                    n_base      = r_base + AW'(TAPS);
                end
            end
            sugf_pkg::S_TAPS: begin
                // Entries past the write position stay unwritten until the first wrap.
                n_tap  = '{valid: 1'b1, clear: (r_k == '0),
                           ent_valid: r_full || (r_ridx <= r_pos), coef: coef_k};
                n_k    = r_k + 1'b1;
                n_ridx = (r_ridx == POS_LAST) ? '0 : r_ridx + 1'b1;
            end
            sugf_pkg::S_FIR_CLIP: begin
                n_res[r_ch] = y_fir;
                n_ch        = r_ch + 1'b1;
                n_base      = r_base + AW'(TAPS);
            end
            sugf_pkg::S_DONE: begin
                if (out_free) begin
                    n_out.out_front_left     = r_res[0] & OUT_MASK;
                    n_out.out_front_right    = r_res[1] & OUT_MASK;
                    n_out.out_surround_left  = r_res[2] & OUT_MASK;
                    n_out.out_surround_right = r_res[3] & OUT_MASK;
                    n_out.out_center         = r_res[4] & OUT_MASK;
                    n_out_valid              = 1'b1;
                    if (r_filt_en) begin
                        if (r_pos == POS_LAST) begin
                            n_pos  = '0;
                            n_full = 1'b1;
                        end else begin
                            n_pos = r_pos + 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sugf_pkg::S_IDLE;
            r_pos       <= '0;
            r_full      <= 1'b0;
            r_tap       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_full      <= n_full;
            r_tap       <= n_tap;
            r_out_valid <= n_out_valid;
        end
        r_l    <= n_l;
        r_r    <= n_r;
        r_ch   <= n_ch;
        r_base <= n_base;
        r_k    <= n_k;
        r_ridx <= n_ridx;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_in_ready  = (r_state == sugf_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("delay position beyond the last tap");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input still ready after a beat was accepted");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == sugf_pkg::S_DONE))
        else $error("result presented outside the completion step");

    a_tap_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tap.valid |-> (r_state == sugf_pkg::S_TAPS || r_state == sugf_pkg::S_DRAIN1))
        else $error("tap product issued outside the filter pass");

endmodule
